// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Invariant that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// ===== hdl/tia_pkg.sv =====
package tia_pkg;

  localparam int POS_W     = 14;
  localparam int BYTES_W   = 11;
  localparam int RES_W     = 17;
  localparam int IDX_CELLS = 2;
  localparam int MOD_CELLS = 6;

  localparam logic [BYTES_W-1:0] BYTES_RESET = 11'd223;
  localparam logic [4:0]         MOD_OFFSET  = 5'd21;

  // One item as it moves down the cell chain.
  typedef struct packed {
    logic             invalid;
    logic             m;
    logic [1:0]       t;
    logic [1:0]       quo;
    logic [RES_W-1:0] rem;
  } item_t;

  // t = (19*i + 1) mod 4 for i in 0..3
  function automatic logic [1:0] t_of_index(input logic [1:0] i);
    logic [1:0] t;
    case (i)
      2'd0:    t = 2'd1;
      2'd1:    t = 2'd0;
      2'd2:    t = 2'd3;
      default: t = 2'd2;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] prime_of(input logic [1:0] t);
    logic [5:0] p;
    case (t)
      2'd0:    p = 6'd31;
      2'd1:    p = 6'd37;
      2'd2:    p = 6'd43;
      default: p = 6'd47;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/tia_div_cell.sv =====
module tia_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [tia_pkg::BYTES_W-1:0]  block_bytes,
  input  logic                         in_valid,
  input  tia_pkg::item_t               in_item,
  output logic                         out_valid,
  output tia_pkg::item_t               out_item
);
  import tia_pkg::*;

  logic [RES_W-1:0] divisor;
  logic             ge;
  item_t            item_next;

  assign divisor = RES_W'(block_bytes) << SHIFT;

  // One restoring step: subtract the shifted divisor when it fits.
  always_comb begin
    item_next = in_item;
    ge        = (in_item.rem >= divisor);
    if (ge) begin
      item_next.rem = in_item.rem - divisor;
    end
    item_next.quo = {in_item.quo[0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== hdl/tia_mul_stage.sv =====
module tia_mul_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           in_valid,
  input  tia_pkg::item_t in_item,
  output logic           out_valid,
  output tia_pkg::item_t out_item
);
  import tia_pkg::*;

  logic [1:0]       t;
  logic [RES_W-1:0] prime_ext;
  logic [RES_W-1:0] j_ext;
  logic [RES_W-1:0] offset;
  item_t            item_next;

  always_comb begin
    t         = t_of_index(in_item.quo);
    prime_ext = RES_W'(prime_of(t));
    j_ext     = RES_W'(in_item.rem[BYTES_W-1:0]);
    offset    = in_item.m ? RES_W'(MOD_OFFSET) : '0;
    item_next         = in_item;
    item_next.t       = t;
    item_next.quo     = '0;
    item_next.rem     = prime_ext * j_ext + offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== hdl/turbo_interleaver_address.sv =====
// CCSDS turbo-code interleaver address generator. Each input transfer carries
// a zero-based bit position; each output transfer returns its interleaved
// position, or zero with position_invalid set when the position is not below
// 8*block_bytes. One address is accepted per clock unless the output stalls.
// The chain holds an input register, two compare/subtract cells that split
// the half position into its quarter index and in-quarter offset, one
// register after the constant-prime multiply, six compare/subtract cells
// that reduce the product modulo block_bytes, and the output register. A
// stall on the output freezes the whole chain, so in_ready follows out_ready
// through one gate. block_bytes resets to 223 and is written through
// cfg_we/cfg_wdata; write it only while no transfer is in flight.
module turbo_interleaver_address (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tia_pkg::BYTES_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tia_pkg::POS_W-1:0]    position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tia_pkg::POS_W-1:0]    permuted_position,
  output logic                         position_invalid
);
  import tia_pkg::*;

`include "assert_macros.svh"

  logic [BYTES_W-1:0] block_bytes;
  logic               advance;

  // Front register
  logic               front_valid;
  item_t              front_item;
  item_t              front_next;

  // Index cells, then the multiply stage, then the modulo cells
  logic  [IDX_CELLS:0] idx_valid;
  item_t               idx_item [IDX_CELLS+1];
  logic  [MOD_CELLS:0] mod_valid;
  item_t               mod_item [MOD_CELLS+1];

  logic [IDX_CELLS+MOD_CELLS+1:0] pipe_valid;
  logic [POS_W-1:0]               result;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BYTES_RESET;
    end else if (cfg_we) begin
      block_bytes <= cfg_wdata;
    end
  end

  // Advance the chain whenever the output register is free or being drained.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_comb begin
    front_next         = '0;
    front_next.invalid = (position >= {block_bytes, 3'b000});
    front_next.m       = position[0];
    front_next.rem     = RES_W'(position[POS_W-1:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (advance) begin
      front_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      front_item <= front_next;
    end
  end

  assign idx_valid[0] = front_valid;
  assign idx_item[0]  = front_item;

  // Quarter index i = floor(n/2 / block_bytes), two bits, most significant first.
  for (genvar g = 0; g < IDX_CELLS; g++) begin : g_idx
    tia_div_cell #(
      .SHIFT(IDX_CELLS - 1 - g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .block_bytes(block_bytes),
      .in_valid   (idx_valid[g]),
      .in_item    (idx_item[g]),
      .out_valid  (idx_valid[g+1]),
      .out_item   (idx_item[g+1])
    );
  end

  // Map i to t, multiply the offset by its prime and add 21 for odd positions.
  tia_mul_stage u_mul (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (idx_valid[IDX_CELLS]),
    .in_item  (idx_item[IDX_CELLS]),
    .out_valid(mod_valid[0]),
    .out_item (mod_item[0])
  );

  // Product stays below 48*block_bytes, so six restoring steps reduce it.
  for (genvar g = 0; g < MOD_CELLS; g++) begin : g_mod
    tia_div_cell #(
      .SHIFT(MOD_CELLS - 1 - g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .block_bytes(block_bytes),
      .in_valid   (mod_valid[g]),
      .in_item    (mod_item[g]),
      .out_valid  (mod_valid[g+1]),
      .out_item   (mod_item[g+1])
    );
  end

  // 2*(t + 4c + 1) - m - 1 = 8c + 2t + (1 - m): plain bit packing.
  assign result = mod_item[MOD_CELLS].invalid ? '0 :
                  {mod_item[MOD_CELLS].rem[BYTES_W-1:0], mod_item[MOD_CELLS].t,
                   ~mod_item[MOD_CELLS].m};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= mod_valid[MOD_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      permuted_position <= result;
      position_invalid  <= mod_item[MOD_CELLS].invalid;
    end
  end

  assign pipe_valid = {mod_valid, idx_valid[IDX_CELLS:1], front_valid};

  `ASSERT_CLK(a_chain_holds, clk, rst, !in_ready |=> $stable(pipe_valid), "chain moved during output stall")
  `ASSERT_CLK(a_invalid_zero, clk, rst, out_valid && position_invalid |-> permuted_position == '0, "invalid position returned nonzero address")
  `ASSERT_CLK(a_in_range, clk, rst, out_valid && !position_invalid |-> permuted_position < {block_bytes, 3'b000}, "permuted address beyond interleaver length")
  `ASSERT_CLK(a_accept_loads, clk, rst, in_valid && in_ready |=> front_valid, "accepted transfer not captured")

endmodule

// ===== tb/turbo_interleaver_address_checker.sv =====
`timescale 1ns / 100ps

module turbo_interleaver_address_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tia_pkg::BYTES_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tia_pkg::POS_W-1:0]    position,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [tia_pkg::POS_W-1:0]    permuted_position,
  input  logic                         position_invalid,
  output int                           pending,
  output int                           fail_count
);

  import tia_pkg::*;

  localparam int unsigned LEG_PRIMES [4] = '{31, 37, 43, 47};
  localparam int unsigned QUARTER_STEP   = 19;
  localparam int unsigned ODD_OFFSET     = 21;

  typedef struct packed {
    logic [POS_W-1:0] perm;
    logic             invalid;
  } interleaved_addr_t;

  logic [BYTES_W-1:0] block_bytes_q = tia_pkg::BYTES_RESET;
  interleaved_addr_t  expected_addrs[$];

  // Interleaver address for bit position pos with block size k2 bytes.
  function automatic interleaved_addr_t interleave_position(
      input logic [POS_W-1:0] pos, input logic [BYTES_W-1:0] k2);
    int unsigned n, len, m, quarter, offset, twist, col;
    interleaved_addr_t r;
    n   = pos;
    len = 8 * k2;
    if (n >= len) begin
      r.perm    = '0;
      r.invalid = 1'b1;
    end else begin
      m       = n % 2;
      quarter = n / (2 * k2);
      offset  = n / 2 - quarter * k2;
      twist   = (QUARTER_STEP * quarter + 1) % 4;
      col     = (LEG_PRIMES[twist] * offset + ODD_OFFSET * m) % k2;
      r.perm    = POS_W'(2 * (twist + 4 * col + 1) - m - 1);
      r.invalid = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : track_edge
    interleaved_addr_t got, want;
    bit bad;
    bad = 1'b0;
    if (rst) begin
      block_bytes_q <= tia_pkg::BYTES_RESET;
      expected_addrs.delete();
    end else begin
      // compare the result first: it can never stem from this edge's input
      if (out_valid && out_ready) begin
        got.perm    = permuted_position;
        got.invalid = position_invalid;
        if (expected_addrs.size() == 0) begin
          $display("%0t: unexpected result perm=%0d invalid=%0b",
                   $time, got.perm, got.invalid);
          bad = 1'b1;
        end else begin
          want = expected_addrs.pop_front();
          if (got.perm !== want.perm) begin
            $display("%0t: permuted_position expected %0d, got %0d",
                     $time, want.perm, got.perm);
            bad = 1'b1;
          end
          if (got.invalid !== want.invalid) begin
            $display("%0t: position_invalid expected %0b, got %0b",
                     $time, want.invalid, got.invalid);
            bad = 1'b1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_addrs.push_back(interleave_position(position, block_bytes_q));
      if (cfg_we)
        block_bytes_q <= cfg_wdata;
    end
    pending <= expected_addrs.size();
    if (bad)
      fail_count <= fail_count + 1;
  end

endmodule

// ===== tb/turbo_interleaver_address_tb.sv =====
`timescale 1ns / 100ps

module turbo_interleaver_address_tb;

  import tia_pkg::*;

  // Pipeline depth of the block plus margin; used before config writes and at the end.
  localparam int PIPE_LATENCY = 11;
  localparam int SETTLE       = PIPE_LATENCY + 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 150;
  localparam int EMPTY_ITEMS  = 40;
  localparam int MAX_POS      = (1 << POS_W) - 1;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [BYTES_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [POS_W-1:0]   position;
  logic               out_valid;
  logic               out_ready;
  logic [POS_W-1:0]   permuted_position;
  logic               position_invalid;

  int pending;
  int fail_count;
  int cycles = 0;

  // Idling is switched off for the final stretch of the run.
  bit                 idle_on = 1'b1;
  logic [BYTES_W-1:0] k2_now = tia_pkg::BYTES_RESET;
  int                 sent_total = 0;
  int                 sent_out_of_range = 0;
  int                 sizes_used = 1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  turbo_interleaver_address dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .position          (position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .permuted_position (permuted_position),
    .position_invalid  (position_invalid)
  );

  turbo_interleaver_address_checker scoreboard (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .position          (position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .permuted_position (permuted_position),
    .position_invalid  (position_invalid),
    .pending           (pending),
    .fail_count        (fail_count)
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver side: random stall bursts between runs of ready.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Called right after a falling edge; returns right after the falling edge
  // that follows the transfer.
  task automatic send_position(input int pos);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= POS_W'(pos);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    if (pos >= 8 * k2_now)
      sent_out_of_range++;
    @(negedge clk);
  endtask

  // Hold the sender until every result is back, then let the pipe settle
  // before touching block_bytes.
  task automatic set_block_bytes(input logic [BYTES_W-1:0] k2);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k2;
    @(negedge clk);
    cfg_we <= 1'b0;
    k2_now = k2;
    sizes_used++;
  endtask

  // Mostly in-range positions; some right at the boundary, some anywhere.
  function automatic int pick_position(input logic [BYTES_W-1:0] k2);
    int sel;
    int len;
    sel = $urandom_range(0, 9);
    len = 8 * k2;
    if (k2 == 0 || sel == 9)
      return $urandom_range(0, MAX_POS);
    if (sel == 8) begin
      if ($urandom_range(0, 1) == 0)
        return len - 1 - $urandom_range(0, 3);
      return (len + $urandom_range(0, 3) > MAX_POS) ? MAX_POS
                                                    : len + $urandom_range(0, 3);
    end
    return $urandom_range(0, len - 1);
  endfunction

  // Empty block, the smallest sizes, the field maximum and both standard
  // ends, then random sizes; the final phase runs with no idling.
  function automatic logic [BYTES_W-1:0] phase_bytes(input int p);
    case (p)
      0:       return BYTES_W'(0);
      1:       return BYTES_W'(1);
      2:       return BYTES_W'((1 << BYTES_W) - 1);
      3:       return BYTES_W'(2);
      4:       return BYTES_W'(1115);
      5:       return BYTES_W'(223);
      6:       return BYTES_W'($urandom_range(223, 1115));
      7:       return BYTES_W'($urandom_range(1, (1 << BYTES_W) - 1));
      8:       return BYTES_W'($urandom_range(3, 222));
      default: return BYTES_W'(1115);
    endcase
  endfunction

  initial begin
    int directed [$];
    int count;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    position  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset size of 223: both parities in every quarter, the last valid
    // position, the first invalid one and the top of the field.
    directed = '{0, 1, 2, 3, 445, 446, 447, 891, 892, 893, 1337, 1338, 1339,
                 1782, 1783, 1784, 1785, 8191, MAX_POS};
    foreach (directed[d])
      send_position(directed[d]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_block_bytes(phase_bytes(p));
      if (p == NUM_PHASES - 1)
        idle_on = 1'b0;
      if (k2_now == 0) begin
        send_position(0);
        send_position(MAX_POS);
      end
      count = (k2_now == 0) ? EMPTY_ITEMS : PHASE_ITEMS;
      for (int k = 0; k < count; k++)
        send_position(pick_position(k2_now));
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d positions over %0d block sizes (empty, 1, 2, 2047 and the",
             sent_total, sizes_used);
    $display("standard ends among them); %0d positions lay beyond the block",
             sent_out_of_range);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatching results", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== turbo_interleaver_address.f =====
+incdir+hdl
hdl/tia_pkg.sv
hdl/tia_div_cell.sv
hdl/tia_mul_stage.sv
hdl/turbo_interleaver_address.sv
tb/turbo_interleaver_address_checker.sv
tb/turbo_interleaver_address_tb.sv
